/* hdl/vertex_view_transform_project_defines.svh */
// ----------------------------------------------------------------------------
// Vertex view transform: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_VIEW_TRANSFORM_PROJECT_DEFINES_SVH
`define VERTEX_VIEW_TRANSFORM_PROJECT_DEFINES_SVH

// same-cycle implication
`define VVTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VVTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/vvtp_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex view transform package
// Shared widths, register codes and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package vvtp_pkg;

  // divider operand widths and quotient bits
  localparam int NUM_W = 46;
  localparam int DEN_W = 33;
  localparam int QB    = 17;

  typedef enum logic [2:0] {
    CFG_CAM_X    = 3'd0,
    CFG_CAM_Y    = 3'd1,
    CFG_CAM_Z    = 3'd2,
    CFG_AZM      = 3'd3,
    CFG_ALT      = 3'd4,
    CFG_ROLL     = 3'd5,
    CFG_SCREEN_W = 3'd6,
    CFG_SCREEN_H = 3'd7
  } vvtp_cfg_e;

  // sideband that rides alongside the divider
  typedef struct packed {
    logic signed [31:0] depth;
    logic               front;
  } vvtp_side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/vvtp_rotate.sv */
// ----------------------------------------------------------------------------
// Plane rotation stage
// a' = a*c - b*s, b' = a*s + b*c, rescaled and saturated; c passes by.
// Two register stages: products, then sum/shift/saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module vvtp_rotate #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] c_i,
  input  logic        [31:0] sc_i,
  output logic signed [31:0] a_o,
  output logic signed [31:0] b_o,
  output logic signed [31:0] c_o
);
  import vvtp_pkg::*;

  logic signed [15:0] sin_w, cos_w;
  logic signed [47:0] ac_q, bs_q, as_q, bc_q;
  logic signed [31:0] c1_q;
  logic signed [48:0] suma_w, sumb_w;
  logic signed [48:0] shfa_w, shfb_w;

  assign sin_w = sc_i[31:16];
  assign cos_w = sc_i[15:0];

  // product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= a_i * cos_w;
      bs_q <= b_i * sin_w;
      as_q <= a_i * sin_w;
      bc_q <= b_i * cos_w;
      c1_q <= c_i;
    end
  end

  // combine, floor shift, saturate
  assign suma_w = 49'(ac_q) - 49'(bs_q);
  assign sumb_w = 49'(as_q) + 49'(bc_q);
  assign shfa_w = suma_w >>> TRIG_FRAC_BITS;
  assign shfb_w = sumb_w >>> TRIG_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= sat32(64'(shfa_w));
      b_o <= sat32(64'(shfb_w));
      c_o <= c1_q;
    end
  end

endmodule

`default_nettype wire

/* hdl/vvtp_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Magnitude quotient, one bit per stage, signed result saturated to 16 bits.
// Stages in order: overflow check, 17 quotient bits, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module vvtp_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [vvtp_pkg::NUM_W-1:0]    num_i,
  input  logic [vvtp_pkg::DEN_W-1:0]    den_i,
  input  logic                          neg_i,
  output logic signed [15:0]            q_o
);
  import vvtp_pkg::*;

  localparam int CW = DEN_W + QB;

  logic [NUM_W-1:0] rem_q [QB+1];
  logic [DEN_W-1:0] den_q [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic             neg_q [QB+1];
  logic             ovf_q [QB+1];

  // load operands; flag a quotient too large for QB bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= CW'(num_i) >= {den_i, {QB{1'b0}}};
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QB; k++) begin : g_bit
    localparam int Sh = QB - k;
    logic [CW:0] trial_w;
    assign trial_w = (CW+1)'(rem_q[k-1]) - (CW+1)'({den_q[k-1], {Sh{1'b0}}});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        if (!trial_w[CW]) begin
          rem_q[k] <= trial_w[NUM_W-1:0];
          quo_q[k] <= quo_q[k-1] | (QB'(1) << Sh);
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
      end
    end
  end

  // apply sign and saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[QB]) begin
        if (ovf_q[QB] || quo_q[QB] > QB'(32768)) begin
          q_o <= 16'sh8000;
        end else begin
          q_o <= 16'(-quo_q[QB]);
        end
      end else begin
        if (ovf_q[QB] || quo_q[QB] > QB'(32767)) begin
          q_o <= 16'sh7FFF;
        end else begin
          q_o <= quo_q[QB][15:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/vertex_view_transform_project.sv */
// Throughput: one vertex per cycle unless the output is held; the two 19-stage
// dividers and the rotation multipliers each take a new operand set every cycle.
// A held output stalls the whole pipeline in place; nothing is lost or repeated.
// Reset clears valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// Vertex view transform and projection, top level
// Translate by camera, three plane rotations, perspective divide.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_view_transform_project_defines.svh"

module vertex_view_transform_project #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  // vertex in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // vert_x, vert_y, vert_z, vert_w
  // result out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // pixel_x, pixel_y, view_depth
  output logic [1:0]   m_axis_tuser   // in_front, on_screen
);
  import vvtp_pkg::*;

  localparam int LAT     = 31;
  localparam int DIV_LAT = 19;

  // configuration registers
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic [31:0]        azm_q, alt_q, roll_q;
  logic [12:0]        scr_w_q, scr_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      azm_q   <= 32'd16384;
      alt_q   <= 32'd16384;
      roll_q  <= 32'd16384;
      scr_w_q <= 13'd640;
      scr_h_q <= 13'd480;
    end else if (cfg_valid_i) begin
      unique case (vvtp_cfg_e'(cfg_index_i))
        CFG_CAM_X:    cam_x_q <= cfg_data_i;
        CFG_CAM_Y:    cam_y_q <= cfg_data_i;
        CFG_CAM_Z:    cam_z_q <= cfg_data_i;
        CFG_AZM:      azm_q   <= cfg_data_i;
        CFG_ALT:      alt_q   <= cfg_data_i;
        CFG_ROLL:     roll_q  <= cfg_data_i;
        CFG_SCREEN_W: scr_w_q <= cfg_data_i[12:0];
        CFG_SCREEN_H: scr_h_q <= cfg_data_i[12:0];
        default:      ;
      endcase
    end
  end

  // global stall when the output register is held
  logic en;
  logic [LAT-1:0] vld_q;

  assign en            = !(vld_q[LAT-1] && !m_axis_tready);
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // stage 1: camera times w
  logic signed [31:0] vx_w, vy_w, vz_w, vw_w;
  logic signed [31:0] vx_q, vy_q, vz_q;
  logic signed [63:0] pcx_q, pcy_q, pcz_q;

  assign vx_w = s_axis_tdata[31:0];
  assign vy_w = s_axis_tdata[63:32];
  assign vz_w = s_axis_tdata[95:64];
  assign vw_w = s_axis_tdata[127:96];

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q  <= vx_w;
      vy_q  <= vy_w;
      vz_q  <= vz_w;
      pcx_q <= cam_x_q * vw_w;
      pcy_q <= cam_y_q * vw_w;
      pcz_q <= cam_z_q * vw_w;
    end
  end

  // stage 2: translate and saturate
  logic signed [31:0] tx_q, ty_q, tz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= sat32(64'(vx_q) - (pcx_q >>> COORD_FRAC_BITS));
      ty_q <= sat32(64'(vy_q) - (pcy_q >>> COORD_FRAC_BITS));
      tz_q <= sat32(64'(vz_q) - (pcz_q >>> COORD_FRAC_BITS));
    end
  end

  // stages 3-8: azimuth (Z), altitude (X), roll (Z)
  logic signed [31:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;

  vvtp_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_azm (
    .clk_i, .en_i(en), .a_i(tx_q), .b_i(ty_q), .c_i(tz_q), .sc_i(azm_q),
    .a_o(x1), .b_o(y1), .c_o(z1)
  );

  vvtp_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_alt (
    .clk_i, .en_i(en), .a_i(y1), .b_i(z1), .c_i(x1), .sc_i(alt_q),
    .a_o(y2), .b_o(z2), .c_o(x2)
  );

  vvtp_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_roll (
    .clk_i, .en_i(en), .a_i(x2), .b_i(y2), .c_i(z2), .sc_i(roll_q),
    .a_o(x3), .b_o(y3), .c_o(z3)
  );

  // stage 9: z + x, in-front test
  logic signed [32:0] sxz_q;
  logic signed [31:0] y9_q, z9_q;
  logic               f9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sxz_q <= 33'(z3) + 33'(x3);
      y9_q  <= y3;
      z9_q  <= z3;
      f9_q  <= z3 > 32'sd0;
    end
  end

  // stage 10: scale products
  logic signed [46:0] nx_q;
  logic signed [45:0] hz_q, wy_q;
  logic signed [31:0] z10_q;
  logic               f10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q  <= $signed({1'b0, scr_w_q}) * sxz_q;
      hz_q  <= $signed({1'b0, scr_h_q}) * z9_q;
      wy_q  <= $signed({1'b0, scr_w_q}) * y9_q;
      z10_q <= z9_q;
      f10_q <= f9_q;
    end
  end

  // stage 11: numerators to magnitude and sign
  logic signed [46:0] ny_w;
  logic [NUM_W-1:0]   nxm_q, nym_q;
  logic               nxn_q, nyn_q;
  logic [DEN_W-1:0]   den_q;
  vvtp_side_t         side11_q;

  assign ny_w = 47'(hz_q) - 47'(wy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nxm_q          <= nx_q[46] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
      nym_q          <= ny_w[46] ? NUM_W'(-ny_w) : NUM_W'(ny_w);
      nxn_q          <= nx_q[46];
      nyn_q          <= ny_w[46];
      den_q          <= {z10_q, 1'b0};
      side11_q.depth <= z10_q;
      side11_q.front <= f10_q;
    end
  end

  // stages 12-30: dividers
  logic signed [15:0] qx, qy;

  vvtp_div u_div_x (
    .clk_i, .en_i(en), .num_i(nxm_q), .den_i(den_q), .neg_i(nxn_q), .q_o(qx)
  );

  vvtp_div u_div_y (
    .clk_i, .en_i(en), .num_i(nym_q), .den_i(den_q), .neg_i(nyn_q), .q_o(qy)
  );

  vvtp_side_t side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side11_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // stage 31: output register
  logic signed [15:0] px_q, py_q;
  logic signed [31:0] depth_q;
  logic               front_q, onscr_q;
  logic               onscr_w;
  vvtp_side_t         side_w;

  assign side_w  = side_q[DIV_LAT-1];
  assign onscr_w = side_w.front && !qx[15] && !qy[15]
                   && ($signed({qx[15], qx}) < $signed({4'b0, scr_w_q}))
                   && ($signed({qy[15], qy}) < $signed({4'b0, scr_h_q}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q    <= side_w.front ? qx : 16'sd0;
      py_q    <= side_w.front ? qy : 16'sd0;
      depth_q <= side_w.depth;
      front_q <= side_w.front;
      onscr_q <= onscr_w;
    end
  end

  assign m_axis_tdata = {depth_q, py_q, px_q};
  assign m_axis_tuser = {onscr_q, front_q};

  // checks
  `VVTP_ASSERT_NOW(a_onscr_front, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "on_screen without in_front")
  `VVTP_ASSERT_NOW(a_back_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0, "pixels not zero behind camera")
  `VVTP_ASSERT_NOW(a_stall_block, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "request taken while output held")
  `VVTP_ASSERT_NXT(a_stall_hold, !en, $stable(vld_q), "pipeline valid bits moved during stall")

endmodule

`default_nettype wire
